[rtl/mlr_pkg.sv]
// shared types and constants for the midpoint line rasterizer
// used by every module under rtl; depends on nothing
package mlr_pkg;

	localparam int COORD_BITS  = 12;
	localparam int WALK_BITS   = COORD_BITS + 1;
	localparam int DEC_BITS    = COORD_BITS + 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [WALK_BITS-1:0]  walk_t;
	typedef logic signed [DEC_BITS-1:0]   dec_t;

	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_TICK = 1'b1
	} mode_t;

	typedef enum logic [2:0] {
		OCT0 = 3'd0,
		OCT1 = 3'd1,
		OCT2 = 3'd2,
		OCT3 = 3'd3,
		OCT4 = 3'd4,
		OCT5 = 3'd5,
		OCT6 = 3'd6,
		OCT7 = 3'd7
	} octant_t;

	typedef struct packed {
		mode_t  mode;
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} mlr_in_t;

	typedef struct packed {
		coord_t  pixel_x;
		coord_t  pixel_y;
		logic    pixel_valid;
		logic    last_pixel;
		octant_t octant;
	} mlr_out_t;

	typedef struct packed {
		walk_t x;
		walk_t y;
	} walk_pair_t;

	// classified word handed from front to back
	typedef struct packed {
		mode_t   mode;
		coord_t  start_x;
		coord_t  start_y;
		octant_t zone;
		walk_t   ax;
		walk_t   ay;
		walk_t   ddx;
		walk_t   ddy;
	} mlr_entry_t;

endpackage

[rtl/midpoint_line_rasterizer.sv]
// midpoint line rasterizer, all eight octants: one word in, one pixel word out
// path: an accepted word is registered in the front stage, written to the queue, then registered at the output
// throughput: one word per cycle while pix_stall is low and the queue has room, set by the single step of the walk unit
// a 4-entry queue decouples the classifying front from the walking back end
// reset clears the queue, the active line and the octant to zero
// top level; depends on mlr_pkg, mlr_front, mlr_queue, mlr_back
module midpoint_line_rasterizer import mlr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mlr_in_t  cmd,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	output mlr_out_t pix,
	output logic     pix_valid,
	input  logic     pix_stall
);

	logic       push, queue_full, pop, queue_not_empty;
	mlr_entry_t push_data, pop_data;

	mlr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.push       (push),
		.push_data  (push_data),
		.queue_full (queue_full)
	);

	mlr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (queue_not_empty)
	);

	mlr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry       (pop_data),
		.entry_valid (queue_not_empty),
		.pop         (pop),
		.pix         (pix),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall)
	);

endmodule

[rtl/mlr_front.sv]
// front end: accepts input words, registers endpoint deltas, classifies the
// octant and mirrors the line into octant 0; depends on mlr_pkg
module mlr_front import mlr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  mlr_in_t    cmd,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	output logic       push,
	output mlr_entry_t push_data,
	input  logic       queue_full
);

	function automatic walk_pair_t to_zero(octant_t z, walk_t x, walk_t y);
		walk_pair_t p;
		unique case (z)
			OCT0: begin p.x = x;  p.y = y;  end
			OCT1: begin p.x = y;  p.y = x;  end
			OCT2: begin p.x = y;  p.y = -x; end
			OCT3: begin p.x = -x; p.y = y;  end
			OCT4: begin p.x = -x; p.y = -y; end
			OCT5: begin p.x = -y; p.y = -x; end
			OCT6: begin p.x = -y; p.y = x;  end
			OCT7: begin p.x = x;  p.y = -y; end
		endcase
		return p;
	endfunction

	logic   valid_s1;
	mode_t  mode_s1;
	coord_t sx_s1, sy_s1;
	walk_t  dx_s1, dy_s1;

	logic                  take;
	logic [COORD_BITS-1:0] mag_x, mag_y;
	logic                  x_major;
	octant_t               zone;
	walk_pair_t            start_m, delta_m;

	assign cmd_stall = valid_s1 & queue_full;
	assign take      = cmd_valid & ~cmd_stall;
	assign push      = valid_s1 & ~queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mode_s1 <= cmd.mode;
			sx_s1   <= cmd.start_x;
			sy_s1   <= cmd.start_y;
			dx_s1   <= WALK_BITS'(cmd.end_x) - WALK_BITS'(cmd.start_x);
			dy_s1   <= WALK_BITS'(cmd.end_y) - WALK_BITS'(cmd.start_y);
		end
	end

	always_comb begin
		mag_x   = dx_s1[WALK_BITS-1] ? COORD_BITS'(-dx_s1) : COORD_BITS'(dx_s1);
		mag_y   = dy_s1[WALK_BITS-1] ? COORD_BITS'(-dy_s1) : COORD_BITS'(dy_s1);
		x_major = mag_x > mag_y;
		priority if (!dx_s1[WALK_BITS-1] && !dy_s1[WALK_BITS-1]) begin
			zone = x_major ? OCT0 : OCT1;
		end else if (!dx_s1[WALK_BITS-1]) begin
			zone = x_major ? OCT7 : OCT6;
		end else if (dy_s1[WALK_BITS-1]) begin
			zone = x_major ? OCT4 : OCT5;
		end else begin
			zone = x_major ? OCT3 : OCT2;
		end
		// the mirror is linear, so the deltas map the same way as the points
		start_m = to_zero(zone, WALK_BITS'(sx_s1), WALK_BITS'(sy_s1));
		delta_m = to_zero(zone, dx_s1, dy_s1);

		push_data.mode    = mode_s1;
		push_data.start_x = sx_s1;
		push_data.start_y = sy_s1;
		push_data.zone    = zone;
		push_data.ax      = start_m.x;
		push_data.ay      = start_m.y;
		push_data.ddx     = delta_m.x;
		push_data.ddy     = delta_m.y;
	end

endmodule

[rtl/mlr_queue.sv]
// short queue of classified words between front and back
// depends on mlr_pkg
module mlr_queue import mlr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  mlr_entry_t push_data,
	output logic       full,
	input  logic       pop,
	output mlr_entry_t pop_data,
	output logic       not_empty
);

	mlr_entry_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]     count_q;

	assign full      = count_q == (QPTR_BITS + 1)'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[rtl/mlr_back.sv]
// back end: holds the line walk state, steps the midpoint decision and
// drives the registered pixel output; depends on mlr_pkg
module mlr_back import mlr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  mlr_entry_t entry,
	input  logic       entry_valid,
	output logic       pop,
	output mlr_out_t   pix,
	output logic       pix_valid,
	input  logic       pix_stall
);

	function automatic walk_pair_t from_zero(octant_t z, walk_t x, walk_t y);
		walk_pair_t p;
		unique case (z)
			OCT0: begin p.x = x;  p.y = y;  end
			OCT1: begin p.x = y;  p.y = x;  end
			OCT2: begin p.x = -y; p.y = x;  end
			OCT3: begin p.x = -x; p.y = y;  end
			OCT4: begin p.x = -x; p.y = -y; end
			OCT5: begin p.x = -y; p.y = -x; end
			OCT6: begin p.x = y;  p.y = -x; end
			OCT7: begin p.x = x;  p.y = -y; end
		endcase
		return p;
	endfunction

	logic                 active_q;
	octant_t              zone_q;
	walk_t                walk_x_q, walk_y_q;
	logic [WALK_BITS-1:0] remain_q;
	dec_t                 dec_q, east_q, diag_q;
	mlr_out_t             out_q;
	logic                 out_valid_q;

	logic       is_load, is_step;
	dec_t       ddx_w, ddy_w;
	walk_t      next_x, next_y;
	walk_pair_t back_m;
	mlr_out_t   result;

	assign pop       = entry_valid & (~out_valid_q | ~pix_stall);
	assign pix       = out_q;
	assign pix_valid = out_valid_q;

	assign is_load = entry.mode == MODE_LOAD;
	assign is_step = (entry.mode == MODE_TICK) & active_q;
	assign ddx_w   = DEC_BITS'(entry.ddx);
	assign ddy_w   = DEC_BITS'(entry.ddy);

	always_comb begin
		next_x = walk_x_q + WALK_BITS'(1);
		// east step when the decision is negative, otherwise north-east
		next_y = dec_q[DEC_BITS-1] ? walk_y_q : walk_y_q + WALK_BITS'(1);
		back_m = from_zero(zone_q, next_x, next_y);

		result.pixel_x     = '0;
		result.pixel_y     = '0;
		result.pixel_valid = 1'b0;
		result.last_pixel  = 1'b0;
		result.octant      = zone_q;
		if (is_load) begin
			result.pixel_x     = entry.start_x;
			result.pixel_y     = entry.start_y;
			result.pixel_valid = 1'b1;
			result.last_pixel  = ~(entry.ddx > 0);
			result.octant      = entry.zone;
		end else if (active_q) begin
			result.pixel_x     = coord_t'(back_m.x[COORD_BITS-1:0]);
			result.pixel_y     = coord_t'(back_m.y[COORD_BITS-1:0]);
			result.pixel_valid = 1'b1;
			result.last_pixel  = remain_q == WALK_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			zone_q      <= OCT0;
			walk_x_q    <= '0;
			walk_y_q    <= '0;
			remain_q    <= '0;
			dec_q       <= '0;
			east_q      <= '0;
			diag_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!pix_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop && is_load) begin
				active_q <= entry.ddx > 0;
				zone_q   <= entry.zone;
				walk_x_q <= entry.ax;
				walk_y_q <= entry.ay;
				remain_q <= entry.ddx;
				dec_q    <= ddy_w + ddy_w - ddx_w;
				east_q   <= ddy_w + ddy_w;
				diag_q   <= (ddy_w - ddx_w) <<< 1;
			end else if (pop && is_step) begin
				walk_x_q <= next_x;
				walk_y_q <= next_y;
				remain_q <= remain_q - 1'b1;
				dec_q    <= dec_q + (dec_q[DEC_BITS-1] ? east_q : diag_q);
				if (remain_q == WALK_BITS'(1)) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= result;
		end
	end

endmodule

[tb/sv/testbench.sv]
// testbench for midpoint_line_rasterizer: directed lines in every octant, then random lines
// a predictor class builds the expected pixel words; depends on mlr_pkg and the rtl only
module testbench;
	import mlr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_MIN   = -(1 << (COORD_BITS - 1));
	localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
	localparam int ITEMS       = 1400;
	localparam int HOLD_CYCLES = 80;
	localparam int IDLE_LIMIT  = 2000;
	localparam int SHOW_LIMIT  = 30;

	typedef enum {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_style_t;

	class line_pixel_checker;
		bit      active;
		octant_t zone;
		walk_t   walk_x;
		walk_t   walk_y;
		walk_t   stop_x;
		dec_t    decision;
		dec_t    east_inc;
		dec_t    diag_inc;
		mlr_out_t pending_pixels[$];
		int      errors;
		int      words_seen;

		function new();
			active   = 0;
			zone     = OCT0;
			walk_x   = '0;
			walk_y   = '0;
			stop_x   = '0;
			decision = '0;
			east_inc = '0;
			diag_inc = '0;
			errors   = 0;
			words_seen = 0;
		endfunction

		function octant_t zone_of(int dx, int dy);
			int ax;
			int ay;
			ax = dx < 0 ? -dx : dx;
			ay = dy < 0 ? -dy : dy;
			if (dx >= 0 && dy >= 0)
				return (ax > ay) ? OCT0 : OCT1;
			if (dx >= 0)
				return (ax > ay) ? OCT7 : OCT6;
			if (dy < 0)
				return (ax > ay) ? OCT4 : OCT5;
			return (ax > ay) ? OCT3 : OCT2;
		endfunction

		// real point into octant 0
		function void fold(octant_t z, int x, int y, output int ox, output int oy);
			case (z)
				OCT0: begin ox = x;  oy = y;  end
				OCT1: begin ox = y;  oy = x;  end
				OCT2: begin ox = y;  oy = -x; end
				OCT3: begin ox = -x; oy = y;  end
				OCT4: begin ox = -x; oy = -y; end
				OCT5: begin ox = -y; oy = -x; end
				OCT6: begin ox = -y; oy = x;  end
				default: begin ox = x; oy = -y; end
			endcase
		endfunction

		// octant-0 point back to real coordinates
		function void unfold(octant_t z, int x, int y, output int ox, output int oy);
			case (z)
				OCT0: begin ox = x;  oy = y;  end
				OCT1: begin ox = y;  oy = x;  end
				OCT2: begin ox = -y; oy = x;  end
				OCT3: begin ox = -x; oy = y;  end
				OCT4: begin ox = -x; oy = -y; end
				OCT5: begin ox = -y; oy = -x; end
				OCT6: begin ox = y;  oy = -x; end
				default: begin ox = x; oy = -y; end
			endcase
		endfunction

		function void note_word(mlr_in_t w);
			mlr_out_t e;
			int sx, sy, ex, ey;
			int ax, ay, bx, by;
			int px, py;
			e = '0;
			if (w.mode == MODE_LOAD) begin
				sx = int'(w.start_x);
				sy = int'(w.start_y);
				ex = int'(w.end_x);
				ey = int'(w.end_y);
				zone = zone_of(ex - sx, ey - sy);
				fold(zone, sx, sy, ax, ay);
				fold(zone, ex, ey, bx, by);
				walk_x   = walk_t'(ax);
				walk_y   = walk_t'(ay);
				stop_x   = walk_t'(bx);
				decision = dec_t'(2 * (by - ay) - (bx - ax));
				east_inc = dec_t'(2 * (by - ay));
				diag_inc = dec_t'(2 * ((by - ay) - (bx - ax)));
				active   = ax < bx;
				e.pixel_x     = w.start_x;
				e.pixel_y     = w.start_y;
				e.pixel_valid = 1'b1;
				e.last_pixel  = !active;
			end else if (active) begin
				walk_x = walk_x + walk_t'(1);
				if (decision < 0) begin
					decision = decision + east_inc;
				end else begin
					walk_y   = walk_y + walk_t'(1);
					decision = decision + diag_inc;
				end
				unfold(zone, int'(walk_x), int'(walk_y), px, py);
				e.pixel_x     = px[COORD_BITS-1:0];
				e.pixel_y     = py[COORD_BITS-1:0];
				e.pixel_valid = 1'b1;
				if (walk_x >= stop_x) begin
					e.last_pixel = 1'b1;
					active = 0;
				end
			end
			e.octant = zone;
			pending_pixels.push_back(e);
		endfunction

		task report(string what);
			errors++;
			if (errors <= SHOW_LIMIT)
				$display("pixel word %0d: %s", words_seen, what);
		endtask

		task check_pixel(mlr_out_t got);
			mlr_out_t e;
			words_seen++;
			if (pending_pixels.size() == 0) begin
				report("arrived with nothing expected");
			end else begin
				e = pending_pixels.pop_front();
				if (got.pixel_x !== e.pixel_x)
					report($sformatf("pixel_x %0d, want %0d", got.pixel_x, e.pixel_x));
				if (got.pixel_y !== e.pixel_y)
					report($sformatf("pixel_y %0d, want %0d", got.pixel_y, e.pixel_y));
				if (got.pixel_valid !== e.pixel_valid)
					report($sformatf("pixel_valid %b, want %b", got.pixel_valid, e.pixel_valid));
				if (got.last_pixel !== e.last_pixel)
					report($sformatf("last_pixel %b, want %b", got.last_pixel, e.last_pixel));
				if (got.octant !== e.octant)
					report($sformatf("octant %0d, want %0d", got.octant, e.octant));
			end
		endtask
	endclass

	logic     clk;
	logic     arst_n;
	mlr_in_t  cmd;
	logic     cmd_valid;
	logic     cmd_stall;
	mlr_out_t pix;
	logic     pix_valid;
	logic     pix_stall;

	line_pixel_checker checker_h = new();
	int items_sent;
	int burst_left;
	int hold_asks;
	int holds_done;
	int idle_cycles;

	midpoint_line_rasterizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.pix       (pix),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// both channels are observed at the rising edge, before any register updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				checker_h.note_word(cmd);
			if (pix_valid && !pix_stall)
				checker_h.check_pixel(pix);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (pix_valid && !pix_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("no word moved for %0d cycles", IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// receiver: stretches of different stall styles, plus long hold-offs on request
	initial begin : receiver
		int stretch;
		stall_style_t style;
		pix_stall = 0;
		forever begin
			if (hold_asks != holds_done) begin
				holds_done++;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					pix_stall <= 1;
				end
			end
			stretch = $urandom_range(10, 120);
			style = stall_style_t'($urandom_range(0, 3));
			repeat (stretch) begin
				@(negedge clk);
				case (style)
					STALL_NONE:  pix_stall <= 0;
					STALL_LIGHT: pix_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: pix_stall <= ($urandom_range(0, 9) < 6);
					default:     pix_stall <= ~pix_stall;
				endcase
				if (hold_asks != holds_done)
					break;
			end
		end
	end

	function automatic int rand_coord();
		case ($urandom_range(0, 19))
			0: return COORD_MIN;
			1: return COORD_MAX;
			default: return int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
		endcase
	endfunction

	function automatic int clamp_coord(int v);
		return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
	endfunction

	// one word, offered in bursts with random gaps; held steady while stalled
	task automatic send_item(mlr_in_t w);
		if (burst_left == 0) begin
			if ($urandom_range(0, 4) != 0) begin
				cmd_valid <= 0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		cmd <= w;
		cmd_valid <= 1;
		do @(posedge clk); while (cmd_stall);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic load_line(int sx, int sy, int ex, int ey);
		mlr_in_t w;
		w.mode    = MODE_LOAD;
		w.start_x = sx[COORD_BITS-1:0];
		w.start_y = sy[COORD_BITS-1:0];
		w.end_x   = ex[COORD_BITS-1:0];
		w.end_y   = ey[COORD_BITS-1:0];
		send_item(w);
	endtask

	// coordinates are ignored on a tick, so they carry noise
	task automatic tick_line(int n);
		mlr_in_t w;
		repeat (n) begin
			w.mode    = MODE_TICK;
			w.start_x = coord_t'($urandom);
			w.start_y = coord_t'($urandom);
			w.end_x   = coord_t'($urandom);
			w.end_y   = coord_t'($urandom);
			send_item(w);
		end
	endtask

	task automatic wait_drained();
		cmd_valid <= 0;
		@(negedge clk);
		while (checker_h.pending_pixels.size() != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		int sx, sy, ex, ey;
		int dx, dy, len, span, pick;
		int next_hold;
		int next_drain;
		arst_n      = 0;
		cmd         = '0;
		cmd_valid   = 0;
		items_sent  = 0;
		burst_left  = 0;
		hold_asks   = 0;
		holds_done  = 0;
		idle_cycles = 0;
		next_hold   = 300;
		next_drain  = 600;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// tick before any line
		tick_line(1);
		// one short line per octant, mostly at the corners of the range
		load_line(COORD_MIN, COORD_MIN, COORD_MIN + 1, COORD_MIN);
		tick_line(1);
		load_line(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN + 1);
		tick_line(1);
		load_line(COORD_MAX, COORD_MAX - 1, COORD_MAX - 1, COORD_MAX);
		tick_line(1);
		load_line(COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX);
		tick_line(1);
		load_line(COORD_MIN + 2, COORD_MIN + 1, COORD_MIN, COORD_MIN);
		tick_line(2);
		load_line(0, 0, -1, -1);
		tick_line(1);
		load_line(-1, 0, -1, -1);
		tick_line(1);
		load_line(COORD_MAX - 2, COORD_MIN + 1, COORD_MAX, COORD_MIN);
		tick_line(2);
		// single point, then a tick with the line finished
		load_line(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
		tick_line(1);
		// full-range diagonal, restarted mid-line by the opposite diagonal
		load_line(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
		tick_line(2);
		load_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
		tick_line(1);
		wait_drained();

		while (items_sent < ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 82) begin
				sx = rand_coord();
				sy = rand_coord();
				if ($urandom_range(0, 19) == 0) begin
					ex = rand_coord();
					ey = rand_coord();
				end else begin
					span = ($urandom_range(0, 3) == 0) ? 40 : 8;
					ex = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
					ey = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
				end
				dx = (ex > sx) ? ex - sx : sx - ex;
				dy = (ey > sy) ? ey - sy : sy - ey;
				len = (dx > dy) ? dx : dy;
				// long lines are cut short by the next load
				if (len > 48)
					len = $urandom_range(1, 48);
				else if ($urandom_range(0, 6) == 0)
					len = $urandom_range(0, len);
				else if ($urandom_range(0, 4) == 0)
					len += $urandom_range(1, 3);
				load_line(sx, sy, ex, ey);
				tick_line(len);
			end else if (pick < 92) begin
				tick_line($urandom_range(1, 4));
			end else begin
				load_line(rand_coord(), rand_coord(), rand_coord(), rand_coord());
			end

			// receiver holds off while words keep coming, so the block backs up
			if (items_sent >= next_hold) begin
				hold_asks++;
				next_hold += 550;
			end
			if (items_sent >= next_drain) begin
				wait_drained();
				next_drain += 450;
			end
		end

		wait_drained();
		repeat (8) @(negedge clk);
		if (checker_h.errors == 0 && checker_h.pending_pixels.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
